// ===== rtl/gll_pkg.sv =====
// Shared types and constants for the GLL field extractor.
package gll_pkg;

  localparam int MAX_TIME_CHARS = 16;
  localparam int TIME_IDX_W     = $clog2(MAX_TIME_CHARS + 1);
  localparam int QUEUE_DEPTH    = 2;
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int QPTR_W         = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  // field_id codes
  localparam logic [2:0] FID_LAT    = 3'd0;
  localparam logic [2:0] FID_LATDIR = 3'd1;
  localparam logic [2:0] FID_LON    = 3'd2;
  localparam logic [2:0] FID_LONDIR = 3'd3;
  localparam logic [2:0] FID_TIME   = 3'd4;
  localparam logic [2:0] FID_DONE   = 3'd5;

  // one result item
  typedef struct packed {
    logic [2:0] fid;
    logic [7:0] ch;
    logic       has;
    logic       last;
    logic       done;
  } gll_res_t;

  // all results caused by one request (cnt is 1..3 when queued)
  typedef struct packed {
    logic [1:0]         cnt;
    gll_res_t [2:0]     res;
  } gll_bundle_t;

endpackage

// ===== rtl/gll_front.sv =====
// Front end: field state machine that turns each request into a result bundle.
module gll_front
  import gll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  logic [7:0]  char_code_i,
  input  logic        has_char_i,
  input  logic        field_end_i,
  output logic        push_o,
  output gll_bundle_t bundle_o
);

  localparam logic [2:0] ST_HEADER = 3'd0;
  localparam logic [2:0] ST_LAT    = 3'd1;
  localparam logic [2:0] ST_LATDIR = 3'd2;
  localparam logic [2:0] ST_LON    = 3'd3;
  localparam logic [2:0] ST_LONDIR = 3'd4;
  localparam logic [2:0] ST_TIME   = 3'd5;
  localparam logic [2:0] ST_FINAL  = 3'd6;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;

  logic [2:0]            state_q, state_d;
  logic [7:0]            held0_q, held0_d, held1_q, held1_d;
  logic [1:0]            hcnt_q, hcnt_d;
  logic                  skip_q, skip_d;
  logic [TIME_IDX_W-1:0] tidx_q, tidx_d;
  logic                  tstop_q, tstop_d;
  logic                  dir_q, dir_d;

  gll_res_t [2:0]        res;
  logic [1:0]            n;
  logic [2:0]            fid;

  always_comb begin
    state_d = state_q;
    held0_d = held0_q;
    held1_d = held1_q;
    hcnt_d  = hcnt_q;
    skip_d  = skip_q;
    tidx_d  = tidx_q;
    tstop_d = tstop_q;
    dir_d   = dir_q;
    res     = '0;
    n       = 2'd0;
    fid     = state_q - 3'd1;

    case (state_q)
      ST_LAT, ST_LON: begin
        if (has_char_i && !(skip_q && char_code_i == CH_ZERO)) begin
          skip_d = 1'b0;
          if (char_code_i == CH_POINT) begin
            res[n] = '{fid: fid, ch: CH_POINT, has: 1'b1, last: 1'b0, done: 1'b0};
            n = n + 2'd1;
            if (hcnt_q != 2'd0) begin
              res[n] = '{fid: fid, ch: held0_q, has: 1'b1, last: 1'b0, done: 1'b0};
              n = n + 2'd1;
            end
            if (hcnt_q == 2'd2) begin
              res[n] = '{fid: fid, ch: held1_q, has: 1'b1, last: 1'b0, done: 1'b0};
              n = n + 2'd1;
            end
            hcnt_d = 2'd0;
          end else if (hcnt_q == 2'd2) begin
            res[n] = '{fid: fid, ch: held0_q, has: 1'b1, last: 1'b0, done: 1'b0};
            n = n + 2'd1;
            held0_d = held1_q;
            held1_d = char_code_i;
          end else if (hcnt_q == 2'd0) begin
            held0_d = char_code_i;
            hcnt_d  = 2'd1;
          end else begin
            held1_d = char_code_i;
            hcnt_d  = 2'd2;
          end
        end
        // end of field flushes the holding buffer
        if (field_end_i) begin
          if (hcnt_d != 2'd0) begin
            res[n] = '{fid: fid, ch: held0_d, has: 1'b1, last: 1'b0, done: 1'b0};
            n = n + 2'd1;
          end
          if (hcnt_d == 2'd2) begin
            res[n] = '{fid: fid, ch: held1_d, has: 1'b1, last: 1'b0, done: 1'b0};
            n = n + 2'd1;
          end
        end
      end
      ST_LATDIR, ST_LONDIR: begin
        if (has_char_i && !dir_q) begin
          res[n] = '{fid: fid, ch: char_code_i, has: 1'b1, last: 1'b0, done: 1'b0};
          n = n + 2'd1;
          dir_d = 1'b1;
        end
      end
      ST_TIME: begin
        if (has_char_i && !tstop_q) begin
          if (char_code_i == CH_POINT) begin
            tstop_d = 1'b1;
          end else if (tidx_q < TIME_IDX_W'(MAX_TIME_CHARS)) begin
            if (tidx_q != '0 && !tidx_q[0]) begin
              res[n] = '{fid: FID_TIME, ch: CH_COLON, has: 1'b1, last: 1'b0, done: 1'b0};
              n = n + 2'd1;
            end
            res[n] = '{fid: FID_TIME, ch: char_code_i, has: 1'b1, last: 1'b0, done: 1'b0};
            n = n + 2'd1;
            tidx_d = tidx_q + TIME_IDX_W'(1);
          end
        end
      end
      ST_FINAL: begin
        if (field_end_i) begin
          res[n] = '{fid: FID_DONE, ch: 8'h00, has: 1'b0, last: 1'b1, done: 1'b1};
          n = n + 2'd1;
        end
      end
      default: begin
        // header and unused codes: no results
      end
    endcase

    if (field_end_i) begin
      if (state_q != ST_HEADER && state_q != ST_FINAL && state_q <= ST_FINAL) begin
        if (n == 2'd0) begin
          res[0] = '{fid: fid, ch: 8'h00, has: 1'b0, last: 1'b0, done: 1'b0};
          n = 2'd1;
        end
        res[n - 2'd1].last = 1'b1;
        state_d = state_q + 3'd1;
      end else if (state_q == ST_FINAL) begin
        state_d = ST_HEADER;
      end else begin
        state_d = ST_LAT;
      end
      held0_d = 8'h00;
      held1_d = 8'h00;
      hcnt_d  = 2'd0;
      skip_d  = 1'b1;
      tidx_d  = '0;
      tstop_d = 1'b0;
      dir_d   = 1'b0;
    end else if (state_q > ST_FINAL) begin
      state_d = ST_HEADER;
    end
  end

  assign push_o       = accept_i && (n != 2'd0);
  assign bundle_o.cnt = n;
  assign bundle_o.res = res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HEADER;
      held0_q <= 8'h00;
      held1_q <= 8'h00;
      hcnt_q  <= 2'd0;
      skip_q  <= 1'b1;
      tidx_q  <= '0;
      tstop_q <= 1'b0;
      dir_q   <= 1'b0;
    end else if (accept_i) begin
      state_q <= state_d;
      held0_q <= held0_d;
      held1_q <= held1_d;
      hcnt_q  <= hcnt_d;
      skip_q  <= skip_d;
      tidx_q  <= tidx_d;
      tstop_q <= tstop_d;
      dir_q   <= dir_d;
    end
  end

endmodule

// ===== rtl/gll_queue.sv =====
// Short bundle queue between the front end and the output serializer.
module gll_queue
  import gll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  gll_bundle_t din_i,
  output logic        full_o,
  input  logic        pop_i,
  output gll_bundle_t dout_o,
  output logic        valid_o
);

  gll_bundle_t         slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   cnt_q;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign dout_o  = slot_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wptr_q] <= din_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_q + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - QCNT_W'(1);
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("bundle pushed into full queue");
  a_bundle_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (dout_o.cnt != 2'd0))
    else $error("empty bundle in queue");

endmodule

// ===== rtl/gll_back.sv =====
// Back end: serializes queued bundles into a registered result stream.
module gll_back
  import gll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  gll_bundle_t head_i,
  input  logic        head_valid_i,
  output logic        pop_o,
  output gll_res_t    res_o,
  output logic        valid_o,
  input  logic        ready_i
);

  gll_res_t   out_q;
  logic       valid_q;
  logic [1:0] idx_q;
  logic       load;
  logic       at_end;

  assign load    = !valid_q || ready_i;
  assign at_end  = ((idx_q + 2'd1) == head_i.cnt);
  assign pop_o   = load && head_valid_i && at_end;
  assign res_o   = out_q;
  assign valid_o = valid_q;

  always_ff @(posedge clk_i) begin
    if (load && head_valid_i) begin
      out_q <= head_i.res[idx_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 2'd0;
    end else if (load) begin
      valid_q <= head_valid_i;
      if (head_valid_i) begin
        idx_q <= at_end ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

endmodule

// ===== rtl/nmea_gll_field_extractor.sv =====
// GLL sentence field extractor: top level with front end, queue and serializer.
// A request's results are written into a queue slot, then loaded into the registered output.
// Throughput: one request per cycle at the input while the queue is not full; results leave
//   at one per cycle while the receiver is ready; a request yields k results (k = 0..3).
// The two-entry bundle queue decouples the state machine from output back-pressure.
// Reset (rst_ni low, async): field state to header, buffers cleared, queue and output empty.
module nmea_gll_field_extractor
  import gll_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] char_code
  input  logic        s_axis_tuser_i,   // [0] has_char
  input  logic        s_axis_tlast_i,   // field_end
  // result stream
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [7:0]  m_axis_tdata_o,   // [7:0] out_char
  output logic [4:0]  m_axis_tuser_o,   // [2:0] field_id, [3] out_has_char, [4] sentence_done
  output logic        m_axis_tlast_o    // last_of_field
);

  logic        accept;
  logic        push;
  gll_bundle_t bundle;
  logic        q_full;
  logic        pop;
  gll_bundle_t head;
  logic        head_valid;
  gll_res_t    res;

  // front stalls only when the queue is full
  assign s_axis_tready_o = !q_full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  gll_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .char_code_i (s_axis_tdata_i),
    .has_char_i  (s_axis_tuser_i),
    .field_end_i (s_axis_tlast_i),
    .push_o      (push),
    .bundle_o    (bundle)
  );

  gll_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .din_i   (bundle),
    .full_o  (q_full),
    .pop_i   (pop),
    .dout_o  (head),
    .valid_o (head_valid)
  );

  gll_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .head_valid_i (head_valid),
    .pop_o        (pop),
    .res_o        (res),
    .valid_o      (m_axis_tvalid_o),
    .ready_i      (m_axis_tready_i)
  );

  assign m_axis_tdata_o = res.ch;
  assign m_axis_tuser_o = {res.done, res.has, res.fid};
  assign m_axis_tlast_o = res.last;

  // completion result is always a closing, empty, field-5 result
  a_done_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res.done) |-> (res.last && !res.has && res.fid == FID_DONE))
    else $error("malformed sentence-done result");
  // an empty result only ever closes a field and carries a zero character
  a_empty_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !res.has) |-> (res.last && res.ch == 8'h00))
    else $error("empty result not closing a field");
  // a stall at the input is caused only by a full queue
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> (head_valid && q_full))
    else $error("input stalled without full queue");

endmodule

// ===== tb/gll_result_checker.sv =====
// Result checker for the GLL field extractor: predicts formatted output and compares.
`timescale 1ns / 1ps

module gll_result_checker
  import gll_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  input  logic       s_ready_i,
  input  logic [7:0] s_data_i,
  input  logic       s_user_i,
  input  logic       s_last_i,
  input  logic       m_valid_i,
  input  logic       m_ready_i,
  input  logic [7:0] m_data_i,
  input  logic [4:0] m_user_i,
  input  logic       m_last_i,
  output int         errors_o,
  output int         pending_o,
  output int         requests_o,
  output int         results_o,
  output int         sentences_o
);

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam int         MAX_PRINTED = 40;

  typedef enum logic [2:0] {
    FS_HEADER, FS_LAT, FS_LATDIR, FS_LON, FS_LONDIR, FS_TIME, FS_FINAL
  } field_state_e;

  field_state_e fstate;
  logic [7:0]   held [2];
  logic [1:0]   held_cnt;
  logic         skip_zeros;
  logic [4:0]   tidx;
  logic         tstop;
  logic         dir_taken;

  gll_res_t     item_res [3];
  int           item_n;
  gll_res_t     formatted_q [$];

  int errors, requests, checked_results, done_sentences;

  function automatic void clear_field();
    held[0]    = '0;
    held[1]    = '0;
    held_cnt   = '0;
    skip_zeros = 1'b1;
    tidx       = '0;
    tstop      = 1'b0;
    dir_taken  = 1'b0;
  endfunction

  function automatic void add_res(logic [2:0] fid, logic [7:0] ch, logic has, logic done);
    if (item_n < 3) begin
      item_res[item_n].fid  = fid;
      item_res[item_n].ch   = has ? ch : 8'h00;
      item_res[item_n].has  = has;
      item_res[item_n].last = 1'b0;
      item_res[item_n].done = done;
      item_n++;
    end
  endfunction

  function automatic void flush_held(logic [2:0] fid);
    for (int i = 0; i < int'(held_cnt) && i < 2; i++) add_res(fid, held[i], 1'b1, 1'b0);
    held_cnt = '0;
  endfunction

  // leading zeros dropped; point moves two places left through the holding pair
  function automatic void coord_char(logic [2:0] fid, logic [7:0] c);
    if (skip_zeros && c == CH_ZERO) return;
    skip_zeros = 1'b0;
    if (c == CH_POINT) begin
      add_res(fid, CH_POINT, 1'b1, 1'b0);
      flush_held(fid);
    end else if (held_cnt >= 2) begin
      add_res(fid, held[0], 1'b1, 1'b0);
      held[0] = held[1];
      held[1] = c;
    end else begin
      held[held_cnt[0]] = c;
      held_cnt++;
    end
  endfunction

  function automatic void time_char(logic [7:0] c);
    if (tstop) return;
    if (c == CH_POINT) begin
      tstop = 1'b1;
      return;
    end
    if (tidx >= MAX_TIME_CHARS) return;
    if (tidx != 0 && !tidx[0]) add_res(FID_TIME, CH_COLON, 1'b1, 1'b0);
    add_res(FID_TIME, c, 1'b1, 1'b0);
    tidx++;
  endfunction

  function automatic void format_request(logic [7:0] c, logic has, logic fend);
    logic [2:0] fid;
    item_n = 0;
    fid    = fstate - 3'd1;
    case (fstate)
      FS_LAT, FS_LON: begin
        if (has) coord_char(fid, c);
        if (fend) flush_held(fid);
      end
      FS_LATDIR, FS_LONDIR: begin
        if (has && !dir_taken) begin
          add_res(fid, c, 1'b1, 1'b0);
          dir_taken = 1'b1;
        end
      end
      FS_TIME: begin
        if (has) time_char(c);
      end
      FS_FINAL: begin
        if (fend) add_res(FID_DONE, 8'h00, 1'b0, 1'b1);
      end
      default: ;
    endcase
    if (fend) begin
      if (fstate == FS_HEADER) begin
        fstate = FS_LAT;
      end else begin
        if (item_n == 0) add_res(fid, 8'h00, 1'b0, 1'b0);
        item_res[item_n-1].last = 1'b1;
        fstate = (fstate == FS_FINAL) ? FS_HEADER : field_state_e'(fstate + 3'd1);
      end
      clear_field();
    end
    for (int i = 0; i < item_n; i++) formatted_q.push_back(item_res[i]);
  endfunction

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    gll_res_t want;
    gll_res_t got;
    if (!rst_ni) begin
      fstate = FS_HEADER;
      clear_field();
      formatted_q.delete();
    end else begin
      if (s_valid_i && s_ready_i) begin
        requests++;
        format_request(s_data_i, s_user_i, s_last_i);
      end
      if (m_valid_i && m_ready_i) begin
        got.fid  = m_user_i[2:0];
        got.ch   = m_data_i;
        got.has  = m_user_i[3];
        got.done = m_user_i[4];
        got.last = m_last_i;
        if (formatted_q.size() == 0) begin
          report_mismatch($sformatf("result fid=%0d ch=%02h with nothing expected",
                                    got.fid, got.ch));
        end else begin
          want = formatted_q.pop_front();
          if (got.fid !== want.fid)
            report_mismatch($sformatf("result %0d field_id %0d, want %0d",
                                      checked_results, got.fid, want.fid));
          if (got.ch !== want.ch)
            report_mismatch($sformatf("result %0d out_char %02h, want %02h",
                                      checked_results, got.ch, want.ch));
          if (got.has !== want.has)
            report_mismatch($sformatf("result %0d out_has_char %0b, want %0b",
                                      checked_results, got.has, want.has));
          if (got.last !== want.last)
            report_mismatch($sformatf("result %0d last_of_field %0b, want %0b",
                                      checked_results, got.last, want.last));
          if (got.done !== want.done)
            report_mismatch($sformatf("result %0d sentence_done %0b, want %0b",
                                      checked_results, got.done, want.done));
          if (want.done) done_sentences++;
        end
        checked_results++;
      end
    end
    errors_o    <= errors;
    pending_o   <= formatted_q.size();
    requests_o  <= requests;
    results_o   <= checked_results;
    sentences_o <= done_sentences;
  end

endmodule

// ===== tb/nmea_gll_field_extractor_test.sv =====
// Testbench top for the GLL field extractor: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module nmea_gll_field_extractor_test;
  import gll_pkg::*;

  localparam int WORK_ITEMS   = 310;  // least number of requests sent, empty and header/final ones included
  localparam int FIELDS_PER_S = 7;    // header .. final, the block walks them in a ring
  localparam int TAIL_CYCLES  = 20;   // quiet cycles after the last result

  // receiver stall patterns, switched every so often
  typedef enum int { RX_OPEN, RX_COIN, RX_PERIODIC, RX_SPARSE } rx_mode_e;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic       s_valid = 1'b0;
  logic [7:0] s_data  = 8'h00;
  logic       s_user  = 1'b0;
  logic       s_last  = 1'b0;
  logic       s_ready;
  logic       m_valid;
  logic       m_ready = 1'b0;
  logic [7:0] m_data;
  logic [4:0] m_user;
  logic       m_last;

  int errors, pending, requests, results, sentences;

  nmea_gll_field_extractor i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // [7:0] char_code
    .s_axis_tuser_i  (s_user),   // [0] has_char
    .s_axis_tlast_i  (s_last),   // field_end
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // [7:0] out_char
    .m_axis_tuser_o  (m_user),   // [2:0] field_id, [3] out_has_char, [4] sentence_done
    .m_axis_tlast_o  (m_last)    // last_of_field
  );

  gll_result_checker i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_valid),
    .s_ready_i   (s_ready),
    .s_data_i    (s_data),
    .s_user_i    (s_user),
    .s_last_i    (s_last),
    .m_valid_i   (m_valid),
    .m_ready_i   (m_ready),
    .m_data_i    (m_data),
    .m_user_i    (m_user),
    .m_last_i    (m_last),
    .errors_o    (errors),
    .pending_o   (pending),
    .requests_o  (requests),
    .results_o   (results),
    .sentences_o (sentences)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // hard stop; the slowest legal run is well under a tenth of this
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // receiver side: ready changes on the falling edge only
  rx_mode_e rx_mode = RX_OPEN;
  int       rx_cyc  = 0;

  always @(negedge clk_i) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 97 == 0) rx_mode <= rx_mode_e'($urandom_range(0, 3));
    case (rx_mode)
      RX_OPEN:     m_ready <= 1'b1;
      RX_COIN:     m_ready <= ($urandom_range(0, 1) == 0);
      RX_PERIODIC: m_ready <= (rx_cyc % 7) > 2;
      default:     m_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  // sender state
  int         burst_left = 0;
  int         field_pos  = 0;  // which field of the ring the block is in; every field_end advances it
  int         work_items = 0;
  bit         paused_mid = 1'b0;
  logic [7:0] fq [$];          // characters of the field being built

  // one request; bursts of random length with random gaps in between
  task automatic put(input logic [7:0] c, input logic has, input logic fend);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i) s_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= c;
    s_user  <= has;
    s_last  <= fend;
    do @(posedge clk_i); while (!s_ready);
    burst_left--;
    work_items++;
    if (fend) field_pos = (field_pos + 1) % FIELDS_PER_S;
  endtask

  // hold the sender off until every predicted result has been taken
  task automatic drain_results();
    @(negedge clk_i) s_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic add_digits(input int n);
    repeat (n) fq.push_back("0" + 8'($urandom_range(0, 9)));
  endtask

  // lat/lon: leading zeros, a point most of the time, now and then a repeat or a stray byte
  task automatic build_coord();
    int r;
    fq.delete();
    r = $urandom_range(0, 19);
    if (r == 0) return;
    repeat ($urandom_range(0, 3)) fq.push_back("0");
    add_digits($urandom_range(0, 5));
    if (r > 3) begin
      fq.push_back(".");
      add_digits($urandom_range(0, 4));
    end
    if (r == 1 || r == 5) begin
      fq.push_back(".");
      add_digits($urandom_range(0, 3));
    end
    if (r == 2 || r == 6) fq.insert($urandom_range(0, fq.size()), 8'($urandom));
  endtask

  task automatic build_dir();
    fq.delete();
    repeat ($urandom_range(0, 3)) begin
      case ($urandom_range(0, 5))
        0:       fq.push_back("N");
        1:       fq.push_back("S");
        2:       fq.push_back("E");
        3:       fq.push_back("W");
        default: fq.push_back(8'($urandom));
      endcase
    end
  endtask

  // time: up to 20 digits, so saturation at MAX_TIME_CHARS can be hit when no point cuts it short
  task automatic build_time();
    fq.delete();
    add_digits($urandom_range(0, 20));
    if ($urandom_range(0, 2) != 0) fq.insert($urandom_range(0, fq.size()), ".");
    if ($urandom_range(0, 7) == 0) fq.insert($urandom_range(0, fq.size()), ".");
    if ($urandom_range(0, 7) == 0) fq.insert($urandom_range(0, fq.size()), 8'($urandom));
  endtask

  task automatic build_letters(input int lo, input int hi);
    fq.delete();
    repeat ($urandom_range(lo, hi)) begin
      if ($urandom_range(0, 4) == 0) fq.push_back(8'($urandom));
      else                           fq.push_back("A" + 8'($urandom_range(0, 25)));
    end
  endtask

  // send fq as one field; stray empty requests inside, sometimes closed by an empty one
  task automatic send_field();
    bit empty_tail;
    empty_tail = ($urandom_range(0, 5) == 0);
    if (fq.size() == 0) begin
      put(8'($urandom), 1'b0, 1'b1);
      return;
    end
    foreach (fq[i]) begin
      if ($urandom_range(0, 11) == 0) put(8'($urandom), 1'b0, 1'b0);
      put(fq[i], 1'b1, (i == fq.size() - 1) && !empty_tail);
    end
    if (empty_tail) put(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic send_sentence();
    // realign after noise: short filler fields until the block sits at the header
    while (field_pos != 0) begin
      fq.delete();
      add_digits($urandom_range(0, 2));
      send_field();
    end
    build_letters(1, 5); send_field();
    build_coord();       send_field();
    build_dir();         send_field();
    build_coord();       send_field();
    build_dir();         send_field();
    build_time();        send_field();
    build_letters(0, 2); send_field();
  endtask

  // broken sequences: fully random requests
  task automatic send_noise();
    repeat ($urandom_range(1, 8)) begin
      put(8'($urandom), 1'($urandom), ($urandom_range(0, 2) == 0));
    end
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed sentence
    put("G", 1'b1, 1'b1);                 // header: no results
    put("0", 1'b1, 1'b0);                 // lat: leading zero dropped
    put("5", 1'b1, 1'b0);
    put(".", 1'b1, 1'b0);                 // point with one held
    put(".", 1'b1, 1'b0);                 // repeated point, nothing held
    put(8'h00, 1'b1, 1'b0);               // code zero is an ordinary char
    put(8'hFF, 1'b0, 1'b1);               // empty request closes, flushes held zero
    put(8'h00, 1'b0, 1'b1);               // lat dir: empty field
    put("1", 1'b1, 1'b0);                 // lon: fill the holding pair
    put("2", 1'b1, 1'b0);
    put(8'hFF, 1'b1, 1'b0);               // pair full, oldest goes out
    put(".", 1'b1, 1'b0);                 // point plus two held
    put("4", 1'b1, 1'b1);
    put("E", 1'b1, 1'b0);                 // lon dir: first char only
    put("W", 1'b1, 1'b1);
    put("1", 1'b1, 1'b0);                 // time: colons between pairs
    put("2", 1'b1, 1'b0);
    put("3", 1'b1, 1'b0);
    put("4", 1'b1, 1'b0);
    put(".", 1'b1, 1'b0);                 // stops at the point
    put("5", 1'b1, 1'b1);
    put("A", 1'b1, 1'b0);                 // final: chars ignored
    put(8'h00, 1'b0, 1'b1);               // sentence done

    drain_results();

    while (work_items < WORK_ITEMS) begin
      if ($urandom_range(0, 9) == 0) send_noise();
      else                           send_sentence();
      if (!paused_mid && work_items >= WORK_ITEMS / 2) begin
        drain_results();
        paused_mid = 1'b1;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d sent); %0d results checked",
             requests, work_items, results);
    $display("%0d sentences completed, receiver stalls and sender gaps throughout", sentences);
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/gll_pkg.sv
rtl/gll_front.sv
rtl/gll_queue.sv
rtl/gll_back.sv
rtl/nmea_gll_field_extractor.sv
tb/gll_result_checker.sv
tb/nmea_gll_field_extractor_test.sv
